[rtl/buddy_page_allocator_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the buddy page allocator
// Wrappers for concurrent checks; they expand to nothing for synthesis.
// ---------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("buddy allocator check failed");
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("buddy allocator check failed");
`else
`define BPA_ASSERT(lbl, clk, rst_n, prop)
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[rtl/bpa_pkg.sv]
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, mark and status codes, control word layout and the microprogram.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int TREE_LEVELS = 10;
  localparam int TOTAL_PAGES = 1 << TREE_LEVELS;
  localparam int NODE_COUNT  = (1 << (TREE_LEVELS + 1)) - 1;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int LVL_W       = $clog2(TREE_LEVELS + 1);
  localparam int PAGE_W      = TREE_LEVELS;
  localparam int MARK_W      = 2;

  localparam int REQ_W       = 11;
  localparam int OFF_W       = 10;
  localparam int BLK_W       = 10;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = ((REQ_W + OFF_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((BLK_W + 7) / 8) * 8;
  localparam int UPC_W       = 6;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [LVL_W-1:0]       lvl_t;
  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [REQ_W-1:0]       req_t;
  typedef logic [OFF_W-1:0]       off_t;
  typedef logic [BLK_W-1:0]       blk_t;
  typedef logic [OUT_TDATA_W-1:0] out_tdata_t;
  typedef logic [UPC_W-1:0]       upc_t;

  typedef enum logic [1:0] {
    MARK_UNUSED = 2'd0,
    MARK_USED   = 2'd1,
    MARK_SPLIT  = 2'd2,
    MARK_FULL   = 2'd3
  } mark_e;

  typedef enum logic [1:0] {
    ST_ALLOC_OK   = 2'd0,
    ST_ALLOC_FAIL = 2'd1,
    ST_FREED      = 2'd2,
    ST_FREE_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MEM_NONE,
    MEM_READ,
    MEM_WRITE
  } mem_op_e;

  typedef enum logic [2:0] {
    ASEL_N,
    ASEL_SIB,
    ASEL_PARENT,
    ASEL_CHILD_L,
    ASEL_CHILD_R
  } addr_sel_e;

  typedef enum logic [2:0] {
    NAV_HOLD,
    NAV_CHILD_L,
    NAV_CHILD_OFF,
    NAV_NEXT,
    NAV_PARENT
  } nav_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_AT_TGT,
    C_UNUSED,
    C_USED,
    C_TAKEN,
    C_FULL,
    C_ODD,
    C_ROOT,
    C_LEAF,
    C_ALIGNED,
    C_REQ_BAD,
    C_OFF_BAD
  } cond_e;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_LATCH,
    RES_ALLOC_OK,
    RES_ALLOC_FAIL,
    RES_FREED,
    RES_FREE_BAD
  } res_e;

  typedef struct packed {
    mem_op_e   mem;
    addr_sel_e asel;
    mark_e     wmark;
    nav_e      nav;
    cond_e     cond;
    logic      inv;
    upc_t      target;
    res_e      res;
  } ctl_t;

  typedef struct packed {
    mark_e mark;
    logic  at_tgt;
    logic  root;
    logic  odd;
    logic  leaf;
    logic  aligned;
    logic  req_bad;
    logic  off_bad;
  } flags_t;

  localparam ctl_t CTL_NOP = '{
    mem:    MEM_NONE,
    asel:   ASEL_N,
    wmark:  MARK_UNUSED,
    nav:    NAV_HOLD,
    cond:   C_NEVER,
    inv:    1'b0,
    target: '0,
    res:    RES_NONE
  };

  // allocate program
  localparam upc_t A_CHK   = upc_t'(0);
  localparam upc_t A_RD    = upc_t'(1);
  localparam upc_t A_TGT   = upc_t'(2);
  localparam upc_t A_FIT   = upc_t'(3);
  localparam upc_t A_USE   = upc_t'(4);
  localparam upc_t A_UP    = upc_t'(5);
  localparam upc_t A_UP_RD = upc_t'(6);
  localparam upc_t A_UP_T  = upc_t'(7);
  localparam upc_t A_UP_W  = upc_t'(8);
  localparam upc_t A_OK    = upc_t'(9);
  localparam upc_t A_DEEP  = upc_t'(10);
  localparam upc_t A_SPL_T = upc_t'(11);
  localparam upc_t A_SPL   = upc_t'(12);
  localparam upc_t A_CLR_L = upc_t'(13);
  localparam upc_t A_CLR_R = upc_t'(14);
  localparam upc_t A_DESC  = upc_t'(15);
  localparam upc_t A_NEXT  = upc_t'(16);
  localparam upc_t A_SIB   = upc_t'(17);
  localparam upc_t A_BACK  = upc_t'(18);
  localparam upc_t A_BK_UP = upc_t'(19);
  localparam upc_t A_BK_T  = upc_t'(20);
  localparam upc_t A_BK_J  = upc_t'(21);
  localparam upc_t A_FAIL  = upc_t'(22);
  // free program
  localparam upc_t F_CHK   = upc_t'(23);
  localparam upc_t F_RD    = upc_t'(24);
  localparam upc_t F_USED  = upc_t'(25);
  localparam upc_t F_ALN   = upc_t'(26);
  localparam upc_t F_REL   = upc_t'(27);
  localparam upc_t F_RL_RD = upc_t'(28);
  localparam upc_t F_RL_T  = upc_t'(29);
  localparam upc_t F_RL_UP = upc_t'(30);
  localparam upc_t F_CLR   = upc_t'(31);
  localparam upc_t F_UPA   = upc_t'(32);
  localparam upc_t F_UA_UP = upc_t'(33);
  localparam upc_t F_UA_RD = upc_t'(34);
  localparam upc_t F_UA_T  = upc_t'(35);
  localparam upc_t F_UA_W  = upc_t'(36);
  localparam upc_t F_OK    = upc_t'(37);
  localparam upc_t F_NU    = upc_t'(38);
  localparam upc_t F_LEAF  = upc_t'(39);
  localparam upc_t F_DESC  = upc_t'(40);
  localparam upc_t F_BAD   = upc_t'(41);

  localparam upc_t UPC_LAST = F_BAD;

  // target tree level for a request: TREE_LEVELS minus ceil(log2(pages))
  function automatic lvl_t target_level(req_t pages);
    req_t pm1;
    int   len;
    pm1 = pages - req_t'(1);
    len = 0;
    for (int i = 0; i < REQ_W; i++) begin
      if (pm1[i]) begin
        len = i + 1;
      end
    end
    return lvl_t'(TREE_LEVELS - len);
  endfunction

  function automatic logic is_finish(res_e r);
    return (r == RES_ALLOC_OK) || (r == RES_ALLOC_FAIL) ||
           (r == RES_FREED) || (r == RES_FREE_BAD);
  endfunction

  // control store
  function automatic ctl_t ucode(upc_t upc);
    ctl_t w;
    w = CTL_NOP;
    case (upc)
      A_CHK: begin
        w.cond = C_REQ_BAD; w.target = A_FAIL;
      end
      A_RD: begin
        w.mem = MEM_READ; w.asel = ASEL_N;
      end
      A_TGT: begin
        w.cond = C_AT_TGT; w.inv = 1'b1; w.target = A_DEEP;
      end
      A_FIT: begin
        w.cond = C_UNUSED; w.inv = 1'b1; w.target = A_NEXT;
      end
      A_USE: begin
        w.mem = MEM_WRITE; w.asel = ASEL_N; w.wmark = MARK_USED; w.res = RES_LATCH;
      end
      A_UP: begin
        w.cond = C_ROOT; w.target = A_OK;
      end
      A_UP_RD: begin
        w.mem = MEM_READ; w.asel = ASEL_SIB;
      end
      A_UP_T: begin
        w.cond = C_TAKEN; w.inv = 1'b1; w.target = A_OK;
      end
      A_UP_W: begin
        w.mem = MEM_WRITE; w.asel = ASEL_PARENT; w.wmark = MARK_FULL;
        w.nav = NAV_PARENT; w.cond = C_ALWAYS; w.target = A_UP;
      end
      A_OK: begin
        w.res = RES_ALLOC_OK;
      end
      A_DEEP: begin
        w.cond = C_TAKEN; w.target = A_NEXT;
      end
      A_SPL_T: begin
        w.cond = C_UNUSED; w.inv = 1'b1; w.target = A_DESC;
      end
      A_SPL: begin
        w.mem = MEM_WRITE; w.asel = ASEL_N; w.wmark = MARK_SPLIT;
      end
      A_CLR_L: begin
        w.mem = MEM_WRITE; w.asel = ASEL_CHILD_L; w.wmark = MARK_UNUSED;
      end
      A_CLR_R: begin
        w.mem = MEM_WRITE; w.asel = ASEL_CHILD_R; w.wmark = MARK_UNUSED;
      end
      A_DESC: begin
        w.nav = NAV_CHILD_L; w.cond = C_ALWAYS; w.target = A_RD;
      end
      A_NEXT: begin
        w.cond = C_ODD; w.inv = 1'b1; w.target = A_BACK;
      end
      A_SIB: begin
        w.nav = NAV_NEXT; w.cond = C_ALWAYS; w.target = A_RD;
      end
      A_BACK: begin
        w.cond = C_ROOT; w.target = A_FAIL;
      end
      A_BK_UP: begin
        w.nav = NAV_PARENT;
      end
      A_BK_T: begin
        w.cond = C_ODD; w.target = A_SIB;
      end
      A_BK_J: begin
        w.cond = C_ALWAYS; w.target = A_BACK;
      end
      A_FAIL: begin
        w.res = RES_ALLOC_FAIL;
      end
      F_CHK: begin
        w.cond = C_OFF_BAD; w.target = F_BAD;
      end
      F_RD: begin
        w.mem = MEM_READ; w.asel = ASEL_N;
      end
      F_USED: begin
        w.cond = C_USED; w.inv = 1'b1; w.target = F_NU;
      end
      F_ALN: begin
        w.cond = C_ALIGNED; w.inv = 1'b1; w.target = F_BAD;
      end
      F_REL: begin
        w.cond = C_ROOT; w.target = F_CLR;
      end
      F_RL_RD: begin
        w.mem = MEM_READ; w.asel = ASEL_SIB;
      end
      F_RL_T: begin
        w.cond = C_UNUSED; w.inv = 1'b1; w.target = F_CLR;
      end
      F_RL_UP: begin
        w.nav = NAV_PARENT; w.cond = C_ALWAYS; w.target = F_REL;
      end
      F_CLR: begin
        w.mem = MEM_WRITE; w.asel = ASEL_N; w.wmark = MARK_UNUSED;
      end
      F_UPA: begin
        w.cond = C_ROOT; w.target = F_OK;
      end
      F_UA_UP: begin
        w.nav = NAV_PARENT;
      end
      F_UA_RD: begin
        w.mem = MEM_READ; w.asel = ASEL_N;
      end
      F_UA_T: begin
        w.cond = C_FULL; w.inv = 1'b1; w.target = F_OK;
      end
      F_UA_W: begin
        w.mem = MEM_WRITE; w.asel = ASEL_N; w.wmark = MARK_SPLIT;
        w.cond = C_ALWAYS; w.target = F_UPA;
      end
      F_OK: begin
        w.res = RES_FREED;
      end
      F_NU: begin
        w.cond = C_UNUSED; w.target = F_BAD;
      end
      F_LEAF: begin
        w.cond = C_LEAF; w.target = F_BAD;
      end
      F_DESC: begin
        w.nav = NAV_CHILD_OFF; w.cond = C_ALWAYS; w.target = F_RD;
      end
      F_BAD: begin
        w.res = RES_FREE_BAD;
      end
      default: begin
        w = CTL_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/bpa_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2047
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bpa_datapath.sv]
// ---------------------------------------------------------------------------
// Buddy allocator datapath
// Node pointer, level, request registers, mark RAM and the clearing pass.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_unit_assert.svh"

module bpa_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  bpa_pkg::req_t   req_i,
  input  bpa_pkg::off_t   off_i,
  input  bpa_pkg::ctl_t   ctl_i,
  output bpa_pkg::flags_t flags_o,
  output logic            clearing_o,
  output bpa_pkg::blk_t   blk_o
);

  bpa_pkg::node_t n_q, n_d;
  bpa_pkg::lvl_t  lvl_q, lvl_d;
  bpa_pkg::lvl_t  tgt_q;
  bpa_pkg::page_t off_q;
  logic           req_bad_q;
  logic           off_bad_q;
  bpa_pkg::blk_t  blk_q;

  logic           clr_q;
  bpa_pkg::node_t clr_addr_q;

  bpa_pkg::node_t sib, par, chl, chr, mem_addr, waddr;
  logic           dir;
  logic           aligned;
  bpa_pkg::node_t rel_idx;
  bpa_pkg::node_t blk_shift;
  logic           we, re;
  logic [bpa_pkg::MARK_W-1:0] wdata, rdata;

  assign sib = n_q[0] ? (n_q + bpa_pkg::node_t'(1)) : (n_q - bpa_pkg::node_t'(1));
  assign par = (n_q - bpa_pkg::node_t'(1)) >> 1;
  assign chl = (n_q << 1) + bpa_pkg::node_t'(1);
  assign chr = (n_q << 1) + bpa_pkg::node_t'(2);

  // free walk: offset bit under the current level picks the child;
  // a used block must start at the offset (low bits below its span zero)
  always_comb begin
    dir     = 1'b0;
    aligned = 1'b1;
    for (int i = 0; i < bpa_pkg::PAGE_W; i++) begin
      if (int'(lvl_q) == bpa_pkg::TREE_LEVELS - 1 - i) begin
        dir = off_q[i];
      end
      if ((i < bpa_pkg::TREE_LEVELS - int'(lvl_q)) && off_q[i]) begin
        aligned = 1'b0;
      end
    end
  end

  // first page of node n at level lvl
  assign rel_idx   = n_q + bpa_pkg::node_t'(1) - (bpa_pkg::node_t'(1) << lvl_q);
  assign blk_shift = rel_idx << (bpa_pkg::lvl_t'(bpa_pkg::TREE_LEVELS) - lvl_q);

  always_comb begin
    case (ctl_i.asel)
      bpa_pkg::ASEL_N:       mem_addr = n_q;
      bpa_pkg::ASEL_SIB:     mem_addr = sib;
      bpa_pkg::ASEL_PARENT:  mem_addr = par;
      bpa_pkg::ASEL_CHILD_L: mem_addr = chl;
      bpa_pkg::ASEL_CHILD_R: mem_addr = chr;
      default:               mem_addr = n_q;
    endcase
  end

  always_comb begin
    n_d   = n_q;
    lvl_d = lvl_q;
    case (ctl_i.nav)
      bpa_pkg::NAV_CHILD_L: begin
        n_d   = chl;
        lvl_d = lvl_q + bpa_pkg::lvl_t'(1);
      end
      bpa_pkg::NAV_CHILD_OFF: begin
        n_d   = dir ? chr : chl;
        lvl_d = lvl_q + bpa_pkg::lvl_t'(1);
      end
      bpa_pkg::NAV_NEXT: begin
        n_d = n_q + bpa_pkg::node_t'(1);
      end
      bpa_pkg::NAV_PARENT: begin
        n_d   = par;
        lvl_d = lvl_q - bpa_pkg::lvl_t'(1);
      end
      default: begin
        n_d   = n_q;
        lvl_d = lvl_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q       <= '0;
      lvl_q     <= '0;
      tgt_q     <= bpa_pkg::target_level(req_i);
      off_q     <= bpa_pkg::page_t'(off_i);
      req_bad_q <= (req_i == '0) || (int'(req_i) > bpa_pkg::TOTAL_PAGES);
      off_bad_q <= int'(off_i) >= bpa_pkg::TOTAL_PAGES;
    end else begin
      n_q   <= n_d;
      lvl_q <= lvl_d;
    end
    if (ctl_i.res == bpa_pkg::RES_LATCH) begin
      blk_q <= bpa_pkg::blk_t'(blk_shift);
    end
  end

  // sweep every mark to unused after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == bpa_pkg::node_t'(bpa_pkg::NODE_COUNT - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + bpa_pkg::node_t'(1);
      end
    end
  end

  assign we    = clr_q || (ctl_i.mem == bpa_pkg::MEM_WRITE);
  assign re    = !clr_q && (ctl_i.mem == bpa_pkg::MEM_READ);
  assign waddr = clr_q ? clr_addr_q : mem_addr;
  assign wdata = clr_q ? bpa_pkg::MARK_UNUSED : ctl_i.wmark;

  bpa_ram #(
    .WIDTH (bpa_pkg::MARK_W),
    .DEPTH (bpa_pkg::NODE_COUNT)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (mem_addr),
    .rdata_o (rdata)
  );

  assign flags_o.mark    = bpa_pkg::mark_e'(rdata);
  assign flags_o.at_tgt  = (lvl_q == tgt_q);
  assign flags_o.root    = (n_q == '0);
  assign flags_o.odd     = n_q[0];
  assign flags_o.leaf    = (int'(lvl_q) >= bpa_pkg::TREE_LEVELS);
  assign flags_o.aligned = aligned;
  assign flags_o.req_bad = req_bad_q;
  assign flags_o.off_bad = off_bad_q;

  assign clearing_o = clr_q;
  assign blk_o      = blk_q;

  `BPA_ASSERT(a_no_op_while_clearing, clk_i, rst_ni, clr_q |-> ctl_i.mem == bpa_pkg::MEM_NONE)
  `BPA_ASSERT(a_free_above_leaf, clk_i, rst_ni, ctl_i.nav == bpa_pkg::NAV_CHILD_OFF |-> int'(lvl_q) < bpa_pkg::TREE_LEVELS)

endmodule

[rtl/bpa_sequencer.sv]
// ---------------------------------------------------------------------------
// Buddy allocator sequencer
// Step counter over the control store, condition select and branching.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_unit_assert.svh"

module bpa_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            kind_i,
  input  bpa_pkg::flags_t flags_i,
  input  logic            out_free_i,
  output bpa_pkg::ctl_t   ctl_o,
  output logic            done_o,
  output logic            running_o
);

  bpa_pkg::upc_t upc_q, upc_d;
  logic          run_q, run_d;
  bpa_pkg::ctl_t word;
  logic          fin, adv, cond, taken;

  assign word = bpa_pkg::ucode(upc_q);
  assign fin  = bpa_pkg::is_finish(word.res);
  // a finishing step waits until the output register has room
  assign adv  = run_q && !(fin && !out_free_i);

  always_comb begin
    case (word.cond)
      bpa_pkg::C_NEVER:   cond = 1'b0;
      bpa_pkg::C_ALWAYS:  cond = 1'b1;
      bpa_pkg::C_AT_TGT:  cond = flags_i.at_tgt;
      bpa_pkg::C_UNUSED:  cond = (flags_i.mark == bpa_pkg::MARK_UNUSED);
      bpa_pkg::C_USED:    cond = (flags_i.mark == bpa_pkg::MARK_USED);
      bpa_pkg::C_TAKEN:   cond = (flags_i.mark == bpa_pkg::MARK_USED) ||
                                 (flags_i.mark == bpa_pkg::MARK_FULL);
      bpa_pkg::C_FULL:    cond = (flags_i.mark == bpa_pkg::MARK_FULL);
      bpa_pkg::C_ODD:     cond = flags_i.odd;
      bpa_pkg::C_ROOT:    cond = flags_i.root;
      bpa_pkg::C_LEAF:    cond = flags_i.leaf;
      bpa_pkg::C_ALIGNED: cond = flags_i.aligned;
      bpa_pkg::C_REQ_BAD: cond = flags_i.req_bad;
      bpa_pkg::C_OFF_BAD: cond = flags_i.off_bad;
      default:            cond = 1'b0;
    endcase
  end

  assign taken = cond ^ word.inv;

  always_comb begin
    upc_d = upc_q;
    run_d = run_q;
    if (start_i) begin
      upc_d = (kind_i == bpa_pkg::KIND_FREE) ? bpa_pkg::F_CHK : bpa_pkg::A_CHK;
      run_d = 1'b1;
    end else if (adv) begin
      upc_d = taken ? word.target : (upc_q + bpa_pkg::upc_t'(1));
      if (fin) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= bpa_pkg::A_CHK;
      run_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      run_q <= run_d;
    end
  end

  assign ctl_o     = adv ? word : bpa_pkg::CTL_NOP;
  assign done_o    = adv && fin;
  assign running_o = run_q;

  `BPA_ASSERT(a_start_when_idle, clk_i, rst_ni, start_i |-> !run_q)
  `BPA_ASSERT_NEXT(a_idle_after_done, clk_i, rst_ni, done_o, !run_q)
  `BPA_ASSERT(a_upc_in_program, clk_i, rst_ni, run_q |-> upc_q <= bpa_pkg::UPC_LAST)

endmodule

[rtl/buddy_page_allocator_unit.sv]
// Sequencing: one control step per cycle from the accepting edge, but a finishing step waits
//   while the output register is full; an allocate walks the tree node by node, splitting
//   unused nodes on its way down and marking parents full on its way back up.
// Throughput: one request at a time; s_axis_tready rises as the result is registered, so a
//   new request is not taken before the last one's result is in the output register.
// Reset: a clearing pass writes every one of the 2047 node marks unused; no beat is taken.
// ---------------------------------------------------------------------------
// Buddy page allocator
// Binary buddy allocator over 2^TREE_LEVELS pages, stream in and stream out.
// ---------------------------------------------------------------------------
`include "buddy_page_allocator_unit_assert.svh"

module buddy_page_allocator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [10:0] request_pages, [20:11] free_offset, rest zero
  input  logic [bpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] block_offset, rest zero
  output logic [bpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [bpa_pkg::STATUS_W-1:0]     m_axis_tuser
);

  logic            accept;
  logic            running, clearing, done, out_free;
  bpa_pkg::ctl_t   ctl;
  bpa_pkg::flags_t flags;
  bpa_pkg::blk_t   blk;
  bpa_pkg::req_t   req;
  bpa_pkg::off_t   off;

  logic             out_valid_q;
  bpa_pkg::status_e out_status_q, out_status_d;
  bpa_pkg::blk_t    out_blk_q, out_blk_d;

  assign s_axis_tready = !running && !clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = s_axis_tdata[bpa_pkg::REQ_W-1:0];
  assign off           = s_axis_tdata[bpa_pkg::REQ_W+bpa_pkg::OFF_W-1:bpa_pkg::REQ_W];
  assign out_free      = !out_valid_q || m_axis_tready;

  bpa_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .kind_i     (s_axis_tuser),
    .flags_i    (flags),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .done_o     (done),
    .running_o  (running)
  );

  bpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .req_i      (req),
    .off_i      (off),
    .ctl_i      (ctl),
    .flags_o    (flags),
    .clearing_o (clearing),
    .blk_o      (blk)
  );

  always_comb begin
    out_blk_d = '0;
    case (ctl.res)
      bpa_pkg::RES_ALLOC_OK: begin
        out_status_d = bpa_pkg::ST_ALLOC_OK;
        out_blk_d    = blk;
      end
      bpa_pkg::RES_ALLOC_FAIL: out_status_d = bpa_pkg::ST_ALLOC_FAIL;
      bpa_pkg::RES_FREED:      out_status_d = bpa_pkg::ST_FREED;
      default:                 out_status_d = bpa_pkg::ST_FREE_BAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_status_q <= out_status_d;
      out_blk_q    <= out_blk_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = bpa_pkg::out_tdata_t'(out_blk_q);
  assign m_axis_tuser  = out_status_q;

  `BPA_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

[tb/sv/tb_buddy_page_allocator_unit.sv]
// ---------------------------------------------------------------------------
// Testbench for the buddy page allocator
// Drives allocate and free beats into the stream input and keeps its own copy
// of the mark tree. Every result beat is checked against the oldest pending
// prediction. Sender gaps and receiver stalls change from phase to phase.
// ---------------------------------------------------------------------------
module tb_buddy_page_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int PHASE_BEATS  = 320;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    bpa_pkg::status_e status;
    bpa_pkg::blk_t    block_offset;
  } alloc_result_t;

  // Mark tree copy plus the queue of results still owed by the block
  class page_tree_tracker;
    bpa_pkg::mark_e marks [bpa_pkg::NODE_COUNT];
    alloc_result_t  pending_results [$];
    int             mismatch_count;

    function new();
      foreach (marks[i]) marks[i] = bpa_pkg::MARK_UNUSED;
      mismatch_count = 0;
    endfunction

    function int unsigned buddy_of(int unsigned n);
      return (n % 2 == 1) ? n + 1 : n - 1;
    endfunction

    function void mark_full_up(int unsigned n);
      while (n != 0) begin
        if (marks[buddy_of(n)] != bpa_pkg::MARK_USED &&
            marks[buddy_of(n)] != bpa_pkg::MARK_FULL) begin
          return;
        end
        n = (n - 1) / 2;
        marks[n] = bpa_pkg::MARK_FULL;
      end
    endfunction

    function bit take_block(int unsigned pages, output int unsigned where);
      int unsigned    want;
      int unsigned    n;
      int unsigned    span;
      int unsigned    lvl;
      bpa_pkg::mark_e m;
      where = 0;
      if (pages == 0 || pages > bpa_pkg::TOTAL_PAGES) return 1'b0;
      want = 1;
      while (want < pages) want = want << 1;
      n    = 0;
      span = bpa_pkg::TOTAL_PAGES;
      lvl  = 0;
      forever begin
        m = marks[n];
        if (want == span) begin
          if (m == bpa_pkg::MARK_UNUSED) begin
            marks[n] = bpa_pkg::MARK_USED;
            mark_full_up(n);
            where = ((n + 1) - (1 << lvl)) << (bpa_pkg::TREE_LEVELS - lvl);
            return 1'b1;
          end
        end else if (m != bpa_pkg::MARK_USED && m != bpa_pkg::MARK_FULL) begin
          if (m == bpa_pkg::MARK_UNUSED) begin
            marks[n]         = bpa_pkg::MARK_SPLIT;
            marks[2 * n + 1] = bpa_pkg::MARK_UNUSED;
            marks[2 * n + 2] = bpa_pkg::MARK_UNUSED;
          end
          n    = 2 * n + 1;
          span = span >> 1;
          lvl++;
          continue;
        end
        if (n % 2 == 1) begin
          n++;
          continue;
        end
        // climb until a left child is found, then step to its right buddy
        forever begin
          if (n == 0) return 1'b0;
          n    = (n - 1) / 2;
          lvl--;
          span = span << 1;
          if (n % 2 == 1) begin
            n++;
            break;
          end
        end
      end
    endfunction

    function void release_node(int unsigned n);
      forever begin
        if (n == 0 || marks[buddy_of(n)] != bpa_pkg::MARK_UNUSED) begin
          marks[n] = bpa_pkg::MARK_UNUSED;
          while (n != 0) begin
            n = (n - 1) / 2;
            if (marks[n] != bpa_pkg::MARK_FULL) break;
            marks[n] = bpa_pkg::MARK_SPLIT;
          end
          return;
        end
        n = (n - 1) / 2;
      end
    endfunction

    function bit give_back(int unsigned off);
      int unsigned    n;
      int unsigned    span;
      int unsigned    left;
      int unsigned    lvl;
      bpa_pkg::mark_e m;
      n    = 0;
      span = bpa_pkg::TOTAL_PAGES;
      left = 0;
      lvl  = 0;
      if (off >= bpa_pkg::TOTAL_PAGES) return 1'b0;
      forever begin
        m = marks[n];
        if (m == bpa_pkg::MARK_USED) begin
          if (off != left) return 1'b0;
          release_node(n);
          return 1'b1;
        end
        if (m == bpa_pkg::MARK_UNUSED || lvl >= bpa_pkg::TREE_LEVELS) return 1'b0;
        span = span >> 1;
        if (off < left + span) begin
          n = 2 * n + 1;
        end else begin
          left = left + span;
          n    = 2 * n + 2;
        end
        lvl++;
      end
    endfunction

    function void note_request(logic kind, bpa_pkg::req_t req, bpa_pkg::off_t off,
                               output alloc_result_t r);
      int unsigned where;
      r.block_offset = '0;
      if (kind == bpa_pkg::KIND_ALLOC) begin
        if (take_block(req, where)) begin
          r.status       = bpa_pkg::ST_ALLOC_OK;
          r.block_offset = bpa_pkg::blk_t'(where);
        end else begin
          r.status = bpa_pkg::ST_ALLOC_FAIL;
        end
      end else begin
        r.status = give_back(off) ? bpa_pkg::ST_FREED : bpa_pkg::ST_FREE_BAD;
      end
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [bpa_pkg::STATUS_W-1:0] st,
                                 bpa_pkg::out_tdata_t data);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat, expected none, actual status %0d offset %0d",
                 $time, st, data[bpa_pkg::BLK_W-1:0]);
        return;
      end
      e = pending_results.pop_front();
      if (st != e.status) begin
        mismatch_count++;
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, st);
      end
      if (data[bpa_pkg::BLK_W-1:0] != e.block_offset) begin
        mismatch_count++;
        $display("%0t: block_offset mismatch, expected %0d, actual %0d",
                 $time, e.block_offset, data[bpa_pkg::BLK_W-1:0]);
      end
      if (data[bpa_pkg::OUT_TDATA_W-1:bpa_pkg::BLK_W] != '0) begin
        mismatch_count++;
        $display("%0t: tdata padding mismatch, expected 0, actual %0h",
                 $time, data[bpa_pkg::OUT_TDATA_W-1:bpa_pkg::BLK_W]);
      end
    endfunction
  endclass

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bpa_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                             s_axis_tuser  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bpa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [bpa_pkg::STATUS_W-1:0]     m_axis_tuser;

  page_tree_tracker tracker = new();
  idle_mode_e       idle_mode = IDLE_NONE;
  int               hold_seq = 0;
  bpa_pkg::off_t    live_blocks [$];

  buddy_page_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    int stall_pct;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_seq;
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 87 : (idle_mode == IDLE_BOTH) ? 8 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_response(m_axis_tuser, m_axis_tdata);
      end
    end
  end

  // offer one request beat and note it once accepted
  task automatic issue(logic kind, bpa_pkg::req_t req, bpa_pkg::off_t off);
    logic [bpa_pkg::IN_TDATA_W-1:0] word;
    alloc_result_t                  r;
    int                             gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 87 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    word                                            = '0;
    word[bpa_pkg::REQ_W-1:0]                        = req;
    word[bpa_pkg::REQ_W+bpa_pkg::OFF_W-1:bpa_pkg::REQ_W] = off;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(kind, req, off, r);
    if (r.status == bpa_pkg::ST_ALLOC_OK) begin
      live_blocks.push_back(bpa_pkg::off_t'(r.block_offset));
    end else if (r.status == bpa_pkg::ST_FREED) begin
      foreach (live_blocks[i]) begin
        if (live_blocks[i] == off) begin
          live_blocks.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    idle_mode_e    phase_modes [5];
    int            r;
    int            alloc_pct;
    int            idx;
    bpa_pkg::req_t req;
    bpa_pkg::off_t off;

    phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: bad sizes, whole tree, misaligned and double frees, no fit
    issue(bpa_pkg::KIND_ALLOC, 11'd0, 10'd1023);
    issue(bpa_pkg::KIND_ALLOC, 11'd1025, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd2047, 10'd1023);
    issue(bpa_pkg::KIND_FREE, 11'd2047, 10'd1023);
    issue(bpa_pkg::KIND_ALLOC, 11'd1024, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd1, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd5);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd1, 10'd1023);
    issue(bpa_pkg::KIND_ALLOC, 11'd3, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd2, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd1, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd2047, 10'd512);
    issue(bpa_pkg::KIND_ALLOC, 11'd512, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd512, 10'd0);
    issue(bpa_pkg::KIND_ALLOC, 11'd1023, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd1);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd2);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd4);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd512);
    issue(bpa_pkg::KIND_ALLOC, 11'd1024, 10'd0);
    issue(bpa_pkg::KIND_FREE, 11'd0, 10'd0);
    wait_for_results();

    foreach (phase_modes[p]) begin
      idle_mode = phase_modes[p];
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (idle_mode == IDLE_NONE && k == 20) hold_seq++;
        off       = bpa_pkg::off_t'($urandom_range(bpa_pkg::TOTAL_PAGES - 1));
        req       = bpa_pkg::req_t'($urandom_range(2047));
        alloc_pct = (live_blocks.size() > 60) ? 30 : 55;
        r         = $urandom_range(99);
        if (r < alloc_pct || (live_blocks.size() == 0 && r < 88)) begin
          r = $urandom_range(99);
          if (r < 3) begin
            req = '0;
          end else if (r < 6) begin
            req = bpa_pkg::req_t'($urandom_range(2047, bpa_pkg::TOTAL_PAGES + 1));
          end else if (r < 8) begin
            req = bpa_pkg::req_t'(($urandom_range(1) == 1) ? bpa_pkg::TOTAL_PAGES : 512);
          end else if (r < 70) begin
            req = bpa_pkg::req_t'($urandom_range(8, 1));
          end else if (r < 90) begin
            req = bpa_pkg::req_t'($urandom_range(64, 9));
          end else begin
            req = bpa_pkg::req_t'($urandom_range(bpa_pkg::TOTAL_PAGES - 1, 65));
          end
          issue(bpa_pkg::KIND_ALLOC, req, off);
        end else if (r < 88) begin
          idx = $urandom_range(live_blocks.size() - 1);
          issue(bpa_pkg::KIND_FREE, req, live_blocks[idx]);
        end else begin
          // broken frees: stray offset, or just past a live block start
          if (live_blocks.size() != 0 && $urandom_range(1) == 1) begin
            idx = $urandom_range(live_blocks.size() - 1);
            off = live_blocks[idx] + bpa_pkg::off_t'($urandom_range(3, 1));
          end
          issue(bpa_pkg::KIND_FREE, req, off);
        end
      end
      wait_for_results();
    end

    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
